>>> design/hlst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hard link seen table package
// Payload types of the channels and the layout of one table entry.
// ----------------------------------------------------------------------------
package hlst_pkg;

	typedef struct packed {
		logic [15:0] device_id;
		logic [31:0] inode_id;
		logic [15:0] link_total;
	} in_item_t;

	typedef struct packed {
		logic seen_before;
		logic table_full;
	} out_item_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] device;
		logic [31:0] inode;
		logic [15:0] remaining;
	} entry_t;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_WRITE = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

endpackage

>>> design/hlst_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hard link seen table channels
// Valid/ready channels for input items, results and configuration writes.
// ----------------------------------------------------------------------------
interface hlst_in_if import hlst_pkg::*; ;
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hlst_out_if import hlst_pkg::*; ;
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hlst_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/hlst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hlst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/hard_link_seen_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hard link seen table core
// Remembers device and inode pairs of files with several hard links.
// ----------------------------------------------------------------------------
// After reset the block sweeps the table once, one entry a cycle, and takes
// no item until the sweep is done; configuration writes are taken at any
// time. An item that bypasses the table (tracking off or a link count of one
// or less) goes straight to the done state. Any other item is looked up by
// reading the table memory one entry per cycle through its single read port,
// up to the last entry; a hit stops the scan at the matching entry. Only one
// item is in work at a time, and the next beat is accepted while a finished
// result still waits in the output register.
// ----------------------------------------------------------------------------
module hard_link_seen_table_core
	import hlst_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	hlst_in_if.sink     in_ch,
	hlst_out_if.source  out_ch,
	hlst_cfg_if.sink    cfg
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = IDX_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_ENTRIES);

	state_t           state_q;
	logic             mode_q;
	in_item_t         key_q;
	logic [CNT_W-1:0] issue_cnt_q;
	logic             chk_vld_s1;
	logic [IDX_W-1:0] chk_idx_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [15:0]      hit_rem_q;
	logic             free_vld_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [IDX_W-1:0] clr_idx_q;
	out_item_t        res_q;
	logic             out_vld_q;
	out_item_t        out_data_q;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_entry;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_entry;
	logic             match;
	logic             empty_slot;
	logic             scan_end;
	logic             in_fire;
	logic             bypass;
	logic             out_load;

	hlst_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_entry),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_entry)
	);

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign in_fire      = in_ch.valid && in_ch.ready;
	assign bypass       = mode_q || (in_ch.data.link_total <= 16'd1);
	assign cfg.ready    = 1'b1;
	assign out_ch.valid = out_vld_q;
	assign out_ch.data  = out_data_q;
	assign out_load     = (state_q == ST_DONE) && (!out_vld_q || out_ch.ready);

	assign rd_en   = (state_q == ST_SCAN) && (issue_cnt_q < DEPTH_CNT);
	assign rd_addr = issue_cnt_q[IDX_W-1:0];

	assign match = chk_vld_s1 && rd_entry.valid
		&& (rd_entry.device == key_q.device_id)
		&& (rd_entry.inode == key_q.inode_id);
	assign empty_slot = chk_vld_s1 && !rd_entry.valid;
	assign scan_end   = chk_vld_s1 && (match || (chk_idx_s1 == LAST_IDX));

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = clr_idx_q;
		wr_entry = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_WRITE: begin
				wr_en = hit_q || free_vld_q;
				wr_entry.device = key_q.device_id;
				wr_entry.inode  = key_q.inode_id;
				if (hit_q) begin
					wr_addr        = hit_idx_q;
					wr_entry.valid = (hit_rem_q > 16'd1);
					wr_entry.remaining = (hit_rem_q > 16'd1) ? hit_rem_q - 16'd1 : 16'd0;
				end else begin
					wr_addr            = free_idx_q;
					wr_entry.valid     = 1'b1;
					wr_entry.remaining = key_q.link_total - 16'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			mode_q      <= 1'b0;
			clr_idx_q   <= '0;
			issue_cnt_q <= '0;
			chk_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			free_vld_q  <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				mode_q <= cfg.data;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					issue_cnt_q <= '0;
					chk_vld_s1  <= 1'b0;
					hit_q       <= 1'b0;
					free_vld_q  <= 1'b0;
					if (in_fire) begin
						state_q <= bypass ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						issue_cnt_q <= issue_cnt_q + 1'b1;
					end
					chk_vld_s1 <= rd_en;
					if (empty_slot && !free_vld_q) begin
						free_vld_q <= 1'b1;
					end
					if (match) begin
						hit_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_addr;
		if (in_fire) begin
			key_q <= in_ch.data;
			res_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (empty_slot && !free_vld_q) begin
				free_idx_q <= chk_idx_s1;
			end
			if (match) begin
				hit_idx_q <= chk_idx_s1;
				hit_rem_q <= rd_entry.remaining;
			end
		end
		if (state_q == ST_WRITE) begin
			res_q.seen_before <= hit_q;
			res_q.table_full  <= !hit_q && !free_vld_q;
		end
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

endmodule
